[sv/complex_number_alu_assert.svh]
// Assertion macros shared by the complex number ALU modules.
`ifndef COMPLEX_NUMBER_ALU_ASSERT_SVH
`define COMPLEX_NUMBER_ALU_ASSERT_SVH

`ifndef ASSERT_OFF

`define CNA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

`define CNA_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: implication failed");

`define CNA_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`else

`define CNA_ASSERT(lbl, clk, rst_n, prop)
`define CNA_ASSERT_IMPLY(lbl, clk, rst_n, pre, post)
`define CNA_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

[sv/cna_pkg.sv]
// Shared constants and types of the complex number ALU.
package cna_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 16;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

endpackage

[sv/complex_number_alu.sv]
// Top level of the complex number ALU: front queue and arithmetic back end.
//   channel  | handshake          | beat
//   input    | valid_i / stall_o  | command_i, a_real_i, a_imag_i, b_real_i, b_imag_i
//   output   | valid_o / stall_i  | result_real_o, result_imag_o, overflow_o,
//            |                    | divide_by_zero_o
// One beat per cycle in and out while stall_i is low; an accepted beat passes the
// queue, the product, sum and prep stages, the divide steps and the output register.
// The restoring divider computes one quotient bit per stage.
// Reset clears the queue and all stage valid bits; no state survives items.
// A stall on the output holds the whole back end; the queue then fills and
// raises stall_o.
module complex_number_alu #(
  parameter int WORD_BITS     = cna_pkg::WORD_BITS,
  parameter int FRACTION_BITS = cna_pkg::FRACTION_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [1:0]                  command_i,
  input  logic signed [WORD_BITS-1:0] a_real_i,
  input  logic signed [WORD_BITS-1:0] a_imag_i,
  input  logic signed [WORD_BITS-1:0] b_real_i,
  input  logic signed [WORD_BITS-1:0] b_imag_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic signed [WORD_BITS-1:0] result_real_o,
  output logic signed [WORD_BITS-1:0] result_imag_o,
  output logic                        overflow_o,
  output logic                        divide_by_zero_o
);

  logic                        q_valid, pop;
  cna_pkg::op_e                q_op;
  logic                        q_dbz;
  logic signed [WORD_BITS-1:0] q_ar, q_ai, q_br, q_bi;

  cna_front #(
    .W     (WORD_BITS),
    .DEPTH (cna_pkg::QUEUE_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_i),
    .stall_o   (stall_o),
    .command_i (command_i),
    .a_real_i  (a_real_i),
    .a_imag_i  (a_imag_i),
    .b_real_i  (b_real_i),
    .b_imag_i  (b_imag_i),
    .pop_i     (pop),
    .q_valid_o (q_valid),
    .q_op_o    (q_op),
    .q_dbz_o   (q_dbz),
    .q_ar_o    (q_ar),
    .q_ai_o    (q_ai),
    .q_br_o    (q_br),
    .q_bi_o    (q_bi)
  );

  cna_back #(
    .W (WORD_BITS),
    .F (FRACTION_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (q_valid),
    .pop_o            (pop),
    .op_i             (q_op),
    .dbz_i            (q_dbz),
    .ar_i             (q_ar),
    .ai_i             (q_ai),
    .br_i             (q_br),
    .bi_i             (q_bi),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .result_real_o    (result_real_o),
    .result_imag_o    (result_imag_o),
    .overflow_o       (overflow_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

endmodule

[sv/cna_front.sv]
// Front end: accepts beats, decodes the command and queues the operands.
module cna_front #(
  parameter int W     = cna_pkg::WORD_BITS,
  parameter int DEPTH = cna_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic [1:0]          command_i,
  input  logic signed [W-1:0] a_real_i,
  input  logic signed [W-1:0] a_imag_i,
  input  logic signed [W-1:0] b_real_i,
  input  logic signed [W-1:0] b_imag_i,
  input  logic                pop_i,
  output logic                q_valid_o,
  output cna_pkg::op_e        q_op_o,
  output logic                q_dbz_o,
  output logic signed [W-1:0] q_ar_o,
  output logic signed [W-1:0] q_ai_o,
  output logic signed [W-1:0] q_br_o,
  output logic signed [W-1:0] q_bi_o
);

  `include "complex_number_alu_assert.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    cna_pkg::op_e        op;
    logic                dbz;
    logic signed [W-1:0] ar;
    logic signed [W-1:0] ai;
    logic signed [W-1:0] br;
    logic signed [W-1:0] bi;
  } entry_t;

  entry_t        mem_q [DEPTH];
  entry_t        wr_entry;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          full, push;

  assign full    = (count_q == CW'(DEPTH));
  assign stall_o = full;
  assign push    = valid_i && !full;

  // classify: decode the operation and flag a zero divisor up front
  always_comb begin
    wr_entry.op  = cna_pkg::op_e'(command_i);
    wr_entry.dbz = (wr_entry.op == cna_pkg::OP_DIV) && (b_real_i == '0) && (b_imag_i == '0);
    wr_entry.ar  = a_real_i;
    wr_entry.ai  = a_imag_i;
    wr_entry.br  = b_real_i;
    wr_entry.bi  = b_imag_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_entry;
    end
  end

  assign q_valid_o = (count_q != '0);
  assign q_op_o    = mem_q[rd_ptr_q].op;
  assign q_dbz_o   = mem_q[rd_ptr_q].dbz;
  assign q_ar_o    = mem_q[rd_ptr_q].ar;
  assign q_ai_o    = mem_q[rd_ptr_q].ai;
  assign q_br_o    = mem_q[rd_ptr_q].br;
  assign q_bi_o    = mem_q[rd_ptr_q].bi;

  `CNA_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `CNA_ASSERT_IMPLY(a_pop_nonempty, clk_i, rst_ni, pop_i, count_q != '0)
  `CNA_ASSERT_NEXT(a_push_count, clk_i, rst_ni, push && !pop_i, count_q == $past(count_q) + 1'b1)

endmodule

[sv/cna_back.sv]
// Back end: product, sum, divide and saturate pipeline with output register.
module cna_back #(
  parameter int W = cna_pkg::WORD_BITS,
  parameter int F = cna_pkg::FRACTION_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                pop_o,
  input  cna_pkg::op_e        op_i,
  input  logic                dbz_i,
  input  logic signed [W-1:0] ar_i,
  input  logic signed [W-1:0] ai_i,
  input  logic signed [W-1:0] br_i,
  input  logic signed [W-1:0] bi_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic signed [W-1:0] result_real_o,
  output logic signed [W-1:0] result_imag_o,
  output logic                overflow_o,
  output logic                divide_by_zero_o
);

  `include "complex_number_alu_assert.svh"

  localparam int SW = 2 * W + 2;
  localparam int RB = 3 * W + F + 2;

  typedef struct packed {
    logic          is_div;
    logic          dbz;
    logic          big_re;
    logic          big_im;
    logic          neg_re;
    logic          neg_im;
    logic          fx_ovf;
    logic [W-1:0]  fx_re;
    logic [W-1:0]  fx_im;
    logic [2*W-1:0] den;
    logic [RB-1:0] rem_re;
    logic [RB-1:0] rem_im;
    logic [W-1:0]  q_re;
    logic [W-1:0]  q_im;
  } dv_t;

  function automatic logic [W:0] sat(input logic signed [SW-1:0] x);
    logic [SW-W:0] hi;
    hi = x[SW-1:W-1];
    if (hi == '0 || hi == '1) begin
      return {1'b0, x[W-1:0]};
    end
    return {1'b1, x[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}};
  endfunction

  function automatic logic [W:0] div_fin(input logic big, input logic neg,
                                         input logic [W-1:0] q);
    logic [W-1:0] mx, mn;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    if (big) begin
      return {1'b1, neg ? mn : mx};
    end else if (neg) begin
      if (q > mn) begin
        return {1'b1, mn};
      end
      return {1'b0, W'(-q)};
    end else if (q[W-1]) begin
      return {1'b1, mx};
    end
    return {1'b0, q};
  endfunction

  logic adv;

  // product stage
  logic                  p_v_q;
  cna_pkg::op_e          p_op_q;
  logic                  p_dbz_q;
  logic signed [W:0]     p_as_re_q, p_as_im_q;
  logic signed [2*W-1:0] m_rr_q, m_ii_q, m_ri_q, m_ir_q, m_b1_q, m_b2_q;
  logic signed [W:0]     ar_x, ai_x, br_x, bi_x;

  // sum stage
  logic                  s_v_q;
  cna_pkg::op_e          s_op_q;
  logic                  s_dbz_q;
  logic signed [W:0]     s_as_re_q, s_as_im_q;
  logic signed [SW-1:0]  s_re_q, s_im_q;
  logic [2*W-1:0]        s_den_q;

  // prep and divide steps
  logic [W:0]            dv_v_q;
  dv_t                   dv_q [W+1];
  dv_t                   prep_d;
  logic [SW-1:0]         mag_re, mag_im;
  logic signed [SW-1:0]  fx_re_w, fx_im_w;
  logic [W:0]            sat_re, sat_im;
  logic [RB-1:0]         den_top;

  // output register
  logic                  out_v_q;
  logic [W-1:0]          out_re_q, out_im_q;
  logic                  out_ovf_q, out_dbz_q;
  logic [W:0]            fin_re, fin_im;

  assign adv   = !out_v_q || !stall_i;
  assign pop_o = adv && in_valid_i;

  assign ar_x = {ar_i[W-1], ar_i};
  assign ai_x = {ai_i[W-1], ai_i};
  assign br_x = {br_i[W-1], br_i};
  assign bi_x = {bi_i[W-1], bi_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q   <= 1'b0;
      s_v_q   <= 1'b0;
      dv_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      p_v_q   <= in_valid_i;
      s_v_q   <= p_v_q;
      dv_v_q  <= {dv_v_q[W-1:0], s_v_q};
      out_v_q <= dv_v_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_op_q    <= op_i;
      p_dbz_q   <= dbz_i;
      p_as_re_q <= (op_i == cna_pkg::OP_SUB) ? ar_x - br_x : ar_x + br_x;
      p_as_im_q <= (op_i == cna_pkg::OP_SUB) ? ai_x - bi_x : ai_x + bi_x;
      m_rr_q    <= ar_i * br_i;
      m_ii_q    <= ai_i * bi_i;
      m_ri_q    <= ar_i * bi_i;
      m_ir_q    <= ai_i * br_i;
      m_b1_q    <= br_i * br_i;
      m_b2_q    <= bi_i * bi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_op_q    <= p_op_q;
      s_dbz_q   <= p_dbz_q;
      s_as_re_q <= p_as_re_q;
      s_as_im_q <= p_as_im_q;
      s_den_q   <= $unsigned(m_b1_q) + $unsigned(m_b2_q);
      if (p_op_q == cna_pkg::OP_DIV) begin
        s_re_q <= SW'(m_rr_q) + SW'(m_ii_q);
        s_im_q <= SW'(m_ir_q) - SW'(m_ri_q);
      end else begin
        s_re_q <= SW'(m_rr_q) - SW'(m_ii_q);
        s_im_q <= SW'(m_ri_q) + SW'(m_ir_q);
      end
    end
  end

  always_comb begin
    mag_re  = s_re_q[SW-1] ? SW'(-s_re_q) : SW'(s_re_q);
    mag_im  = s_im_q[SW-1] ? SW'(-s_im_q) : SW'(s_im_q);
    fx_re_w = (s_op_q == cna_pkg::OP_MUL) ? (s_re_q >>> F) : SW'(s_as_re_q);
    fx_im_w = (s_op_q == cna_pkg::OP_MUL) ? (s_im_q >>> F) : SW'(s_as_im_q);
    sat_re  = sat(fx_re_w);
    sat_im  = sat(fx_im_w);
    den_top = RB'(s_den_q) << W;
    prep_d.is_div = (s_op_q == cna_pkg::OP_DIV);
    prep_d.dbz    = s_dbz_q;
    prep_d.neg_re = s_re_q[SW-1];
    prep_d.neg_im = s_im_q[SW-1];
    prep_d.rem_re = RB'(mag_re) << F;
    prep_d.rem_im = RB'(mag_im) << F;
    prep_d.big_re = (prep_d.rem_re >= den_top);
    prep_d.big_im = (prep_d.rem_im >= den_top);
    prep_d.fx_ovf = sat_re[W] | sat_im[W];
    prep_d.fx_re  = sat_re[W-1:0];
    prep_d.fx_im  = sat_im[W-1:0];
    prep_d.den    = s_den_q;
    prep_d.q_re   = '0;
    prep_d.q_im   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= prep_d;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < W; j++) begin : g_step
    localparam int B = W - 1 - j;
    logic [RB-1:0] dsh;
    dv_t           nx;
    always_comb begin
      dsh = RB'(dv_q[j].den) << B;
      nx  = dv_q[j];
      if (dv_q[j].rem_re >= dsh) begin
        nx.rem_re  = dv_q[j].rem_re - dsh;
        nx.q_re[B] = 1'b1;
      end
      if (dv_q[j].rem_im >= dsh) begin
        nx.rem_im  = dv_q[j].rem_im - dsh;
        nx.q_im[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[j+1] <= nx;
      end
    end
  end

  assign fin_re = div_fin(dv_q[W].big_re, dv_q[W].neg_re, dv_q[W].q_re);
  assign fin_im = div_fin(dv_q[W].big_im, dv_q[W].neg_im, dv_q[W].q_im);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!dv_q[W].is_div) begin
        out_re_q  <= dv_q[W].fx_re;
        out_im_q  <= dv_q[W].fx_im;
        out_ovf_q <= dv_q[W].fx_ovf;
        out_dbz_q <= 1'b0;
      end else if (dv_q[W].dbz) begin
        out_re_q  <= '0;
        out_im_q  <= '0;
        out_ovf_q <= 1'b0;
        out_dbz_q <= 1'b1;
      end else begin
        out_re_q  <= fin_re[W-1:0];
        out_im_q  <= fin_im[W-1:0];
        out_ovf_q <= fin_re[W] | fin_im[W];
        out_dbz_q <= 1'b0;
      end
    end
  end

  assign valid_o          = out_v_q;
  assign result_real_o    = out_re_q;
  assign result_imag_o    = out_im_q;
  assign overflow_o       = out_ovf_q;
  assign divide_by_zero_o = out_dbz_q;

  `CNA_ASSERT_IMPLY(a_dbz_zero, clk_i, rst_ni, out_v_q && out_dbz_q, out_re_q == '0 && out_im_q == '0 && !out_ovf_q)
  `CNA_ASSERT_NEXT(a_hold_pipe, clk_i, rst_ni, !adv, $stable(dv_v_q) && $stable(p_v_q))
  `CNA_ASSERT_IMPLY(a_dbz_div, clk_i, rst_ni, dv_v_q[W] && dv_q[W].dbz, dv_q[W].is_div)

endmodule

[sim/complex_number_alu_checker.sv]
// Predicts complex ALU results from observed input beats and checks output beats.
module complex_number_alu_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic               stall_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] a_real_i,
  input  logic signed [31:0] a_imag_i,
  input  logic signed [31:0] b_real_i,
  input  logic signed [31:0] b_imag_i,
  input  logic               valid_o,
  input  logic               stall_i,
  input  logic signed [31:0] result_real_o,
  input  logic signed [31:0] result_imag_o,
  input  logic               overflow_o,
  input  logic               divide_by_zero_o,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               ovf;
    logic               dbz;
  } alu_result_t;

  alu_result_t result_fifo[$];

  function automatic logic signed [31:0] clamp_word(input logic signed [127:0] x,
                                                    inout logic ovf);
    if (x > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                    input logic signed [127:0] d);
    logic [127:0] un;
    logic [127:0] ud;
    logic [127:0] q;
    un = n[127] ? -n : n;
    ud = d[127] ? -d : d;
    q = un / ud;
    return (n[127] != d[127]) ? -$signed(q) : $signed(q);
  endfunction

  function automatic alu_result_t compute_alu(input logic [1:0] cmd,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi);
    logic signed [127:0] wr, wi, xr, xi, yr, yi, re, im, den;
    alu_result_t r;
    logic ovf;
    wr = ar; wi = ai; xr = br; xi = bi;
    r = '0;
    ovf = 1'b0;
    unique case (cna_pkg::op_e'(cmd))
      cna_pkg::OP_ADD: begin re = wr + xr; im = wi + xi; end
      cna_pkg::OP_SUB: begin re = wr - xr; im = wi - xi; end
      cna_pkg::OP_MUL: begin
        re = (wr * xr - wi * xi) >>> cna_pkg::FRACTION_BITS;
        im = (wr * xi + xr * wi) >>> cna_pkg::FRACTION_BITS;
      end
      default: begin
        den = xr * xr + xi * xi;
        if (den == 0) begin
          r.dbz = 1'b1;
          re = 0;
          im = 0;
        end else begin
          yr = (wr * xr + wi * xi) <<< cna_pkg::FRACTION_BITS;
          yi = (xr * wi - wr * xi) <<< cna_pkg::FRACTION_BITS;
          re = div_trunc(yr, den);
          im = div_trunc(yi, den);
        end
      end
    endcase
    r.re = clamp_word(re, ovf);
    r.im = clamp_word(im, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;
  assign pending_o = result_fifo.size();

  always @(posedge clk_i) begin
    alu_result_t w;
    if (rst_ni) begin
      if (valid_i && !stall_o)
        result_fifo.push_back(compute_alu(command_i, a_real_i, a_imag_i,
                                          b_real_i, b_imag_i));
      if (valid_o && !stall_i) begin
        if (result_fifo.size() == 0) begin
          report_mismatch("unexpected beat", result_real_o, 0);
        end else begin
          w = result_fifo.pop_front();
          if (result_real_o !== w.re) report_mismatch("result_real", result_real_o, w.re);
          if (result_imag_o !== w.im) report_mismatch("result_imag", result_imag_o, w.im);
          if (overflow_o !== w.ovf) report_mismatch("overflow", overflow_o, w.ovf);
          if (divide_by_zero_o !== w.dbz)
            report_mismatch("divide_by_zero", divide_by_zero_o, w.dbz);
        end
      end
    end
  end
endmodule

[sim/tb.sv]
// Stimulus and verdict for the complex number ALU.
module tb;

  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk_i, rst_ni;
  logic               valid_i, stall_o, valid_o, stall_i;
  logic [1:0]         command_i;
  logic signed [31:0] a_real_i, a_imag_i, b_real_i, b_imag_i;
  logic signed [31:0] result_real_o, result_imag_o;
  logic               overflow_o, divide_by_zero_o;
  int                 fail_count, pending, idle_cycles;
  logic               in_done;

  complex_number_alu u_top (.*);

  complex_number_alu_checker u_chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] pick_word();
    unique case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'h00010000;
      4: return 32'hffff0000;
      5: return $urandom_range(0, 255);
      6, 7: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input cna_pkg::op_e cmd, input logic [31:0] ar,
                           input logic [31:0] ai, input logic [31:0] br,
                           input logic [31:0] bi);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    command_i <= cmd;
    a_real_i <= ar; a_imag_i <= ai; b_real_i <= br; b_imag_i <= bi;
    do @(posedge clk_i); while (stall_o);
  endtask

  initial begin
    int n;
    valid_i = 1'b0; command_i = cna_pkg::OP_ADD; in_done = 1'b0;
    a_real_i = 0; a_imag_i = 0; b_real_i = 0; b_imag_i = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int c = 0; c < 4; c++) begin
      send_beat(cna_pkg::op_e'(c), 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      send_beat(cna_pkg::op_e'(c), 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
      send_beat(cna_pkg::op_e'(c), 32'h00010000, 32'hffff0000, 32'h00020000, 32'h00008000);
      send_beat(cna_pkg::op_e'(c), 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0);
    end
    send_beat(cna_pkg::OP_DIV, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'h0);
    send_beat(cna_pkg::OP_DIV, 32'h00050000, 32'h00030000, 32'hffffffff, 32'hffffffff);
    send_beat(cna_pkg::OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
    for (n = 0; n < 800; n++)
      send_beat(cna_pkg::op_e'($urandom_range(0, 3)), pick_word(), pick_word(),
                pick_word(), pick_word());
    valid_i <= 1'b0;
    in_done <= 1'b1;
  end

  initial begin
    stall_i = 1'b0;
    forever begin
      int hold;
      @(posedge clk_i);
      if (valid_o && !stall_i) begin
        hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (hold > 0) begin
          stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
          stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (in_done && pending == 0) begin
        repeat (50) @(posedge clk_i);
        if (fail_count == 0 && pending == 0) $display("complex_number_alu verification clean");
        else $display("complex_number_alu verification failed");
        $finish;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("complex_number_alu verification failed");
        $finish;
      end
    end
  end
endmodule

[files.f]
+incdir+sv
sv/cna_pkg.sv
sv/cna_front.sv
sv/cna_back.sv
sv/complex_number_alu.sv
sim/complex_number_alu_checker.sv
sim/tb.sv
